// ===== design/wppf_pkg.sv =====
// ----------------------------------------------------------------------------
// wppf_pkg
// Shared types and constants for the pedestal-subtracted peak finder.
// ----------------------------------------------------------------------------
package wppf_pkg;

  localparam int CMD_W   = 1;
  localparam int CHAN_W  = 5;
  localparam int IDX_W   = 10;
  localparam int ADCIN_W = 12;
  localparam int PED_W   = 18;
  localparam int HGT_W   = 19;
  localparam int SUM_W   = 22;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int QDIV_W  = SUM_W + 6;

  localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PROMPT_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PED_FIRST      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PED_COUNT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_FIRST     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_LAST      = 3'd5;

  // Work handed from the front end to the back end once a window closes.
  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic               prompt;
    logic [SUM_W-1:0]   sum;
    logic [PED_W-1:0]   fixed_ped;
    logic [ADCIN_W-1:0] minimum;
  } wppf_job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_RESULT
  } wppf_state_t;

endpackage

// ===== design/wppf_ram.sv =====
// ----------------------------------------------------------------------------
// wppf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wppf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/wppf_front.sv =====
// ----------------------------------------------------------------------------
// wppf_front
// Accepts samples and loads, keeps per-channel sums, minima and pedestals.
// ----------------------------------------------------------------------------
module wppf_front #(
  parameter int CHANNELS = 32,
  parameter int ADC_BITS = 12,
  parameter int SAMPLES_PER_EVENT = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wppf_pkg::CMD_W-1:0]      command,
  input  logic [wppf_pkg::CHAN_W-1:0]     channel,
  input  logic [wppf_pkg::IDX_W-1:0]      sample_index,
  input  logic [wppf_pkg::ADCIN_W-1:0]    adc_value,
  input  logic [wppf_pkg::PED_W-1:0]      pedestal_load,
  input  logic                            prompt_mode,
  input  logic [31:0]                     channel_enable,
  input  logic [wppf_pkg::IDX_W-1:0]      ped_first,
  input  logic [wppf_pkg::IDX_W-1:0]      ped_count,
  input  logic [wppf_pkg::IDX_W-1:0]      peak_first,
  input  logic [wppf_pkg::IDX_W-1:0]      peak_last,
  output logic                            job_valid,
  output wppf_pkg::wppf_job_t             job,
  input  logic                            job_ready
);
  import wppf_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [ADCIN_W-1:0] ADC_MAX = ADCIN_W'((1 << ADC_BITS) - 1);
  localparam logic [PED_W-1:0]   PED_MAX = PED_W'(((1 << ADC_BITS) - 1) << 6);
  localparam logic [SUM_W-1:0]   SUM_MAX = '1;

  // Stage 1 register: accepted sample, state read in flight.
  logic               s1_valid;
  logic               s1_ped_start, s1_ped_add;
  logic               s1_pk_start, s1_pk_emit;
  logic               s1_is_load;
  logic [CHAN_W-1:0]  s1_chan;
  logic [ADCIN_W-1:0] s1_adc;
  logic [PED_W-1:0]   s1_load;
  logic [CHANNELS-1:0] sum_vld, min_vld, fix_vld;

  logic [SUM_W-1:0]   sum_rd, sum_cur, sum_new;
  logic [ADCIN_W-1:0] min_rd, min_cur, min_new;
  logic [PED_W-1:0]   fix_rd, fix_cur, fix_new;
  logic [SUM_W:0]     sum_add;
  logic               stall;
  logic               acc;
  logic               in_range, ch_ok, en_ok;
  logic [IDX_W:0]     ped_end;
  logic [CH_W-1:0]    rd_ch, s1_ch;
  logic               sum_we, min_we, fix_we;

  // Sequential front: the next item waits for this one's write-back so that
  // same-channel read-after-write is safe.
  assign stall    = s1_valid;
  assign in_ready = !stall && !(job_valid && !job_ready);
  assign acc      = in_valid && in_ready;

  assign ch_ok    = 32'(channel) < 32'(CHANNELS);
  assign in_range = 32'(sample_index) < 32'(SAMPLES_PER_EVENT);
  assign en_ok    = channel_enable[channel];
  assign ped_end  = {1'b0, ped_first} + {1'b0, ped_count};
  assign rd_ch    = CH_W'(channel);
  assign s1_ch    = CH_W'(s1_chan);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc && ch_ok;
    end
    s1_chan  <= channel;
    s1_adc   <= adc_value & ADC_MAX;
    s1_load  <= (pedestal_load > PED_MAX) ? PED_MAX : pedestal_load;
    s1_is_load <= command == CMD_LOAD;
    s1_ped_start <= (command == CMD_SAMPLE) && en_ok && in_range && ped_count != '0 &&
                    sample_index == ped_first;
    s1_ped_add <= (command == CMD_SAMPLE) && en_ok && in_range && ped_count != '0 &&
                  sample_index > ped_first && {1'b0, sample_index} < ped_end;
    s1_pk_start <= (command == CMD_SAMPLE) && en_ok && in_range &&
                   peak_first <= peak_last && sample_index == peak_first;
    s1_pk_emit <= (command == CMD_SAMPLE) && en_ok && in_range &&
                  peak_first <= peak_last && sample_index >= peak_first &&
                  sample_index <= peak_last;
  end

  wppf_ram #(.WIDTH(SUM_W), .DEPTH(CHANNELS)) u_sum (
    .clk(clk), .we(sum_we), .waddr(s1_ch), .wdata(sum_new), .raddr(rd_ch), .rdata(sum_rd));
  wppf_ram #(.WIDTH(ADCIN_W), .DEPTH(CHANNELS)) u_min (
    .clk(clk), .we(min_we), .waddr(s1_ch), .wdata(min_new), .raddr(rd_ch), .rdata(min_rd));
  wppf_ram #(.WIDTH(PED_W), .DEPTH(CHANNELS)) u_fix (
    .clk(clk), .we(fix_we), .waddr(s1_ch), .wdata(fix_new), .raddr(rd_ch), .rdata(fix_rd));

  // Entries never written read as their reset values.
  assign sum_cur = sum_vld[s1_ch] ? sum_rd : '0;
  assign min_cur = min_vld[s1_ch] ? min_rd : ADC_MAX;
  assign fix_cur = fix_vld[s1_ch] ? fix_rd : '0;

  assign sum_add = {1'b0, sum_cur} + (SUM_W+1)'(s1_adc);
  always_comb begin
    sum_new = sum_cur;
    if (s1_ped_start) begin
      sum_new = SUM_W'(s1_adc);
    end else if (s1_ped_add) begin
      sum_new = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    end
    min_new = min_cur;
    if (s1_pk_start || s1_adc < min_cur) begin
      min_new = s1_adc;
    end
    fix_new = s1_load;
  end

  assign sum_we = s1_valid && !s1_is_load && (s1_ped_start || s1_ped_add);
  assign min_we = s1_valid && !s1_is_load && s1_pk_emit;
  assign fix_we = s1_valid && s1_is_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= '0;
      min_vld <= '0;
      fix_vld <= '0;
    end else begin
      if (sum_we) sum_vld[s1_ch] <= 1'b1;
      if (min_we) min_vld[s1_ch] <= 1'b1;
      if (fix_we) fix_vld[s1_ch] <= 1'b1;
    end
  end

  // Job register: one entry of queue toward the back end.
  logic s1_last;
  logic [IDX_W-1:0] s1_idx;
  always_ff @(posedge clk) begin
    s1_idx <= sample_index;
  end
  assign s1_last = s1_idx == peak_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (min_we && s1_last) begin
      job_valid <= 1'b1;
    end else if (job_ready) begin
      job_valid <= 1'b0;
    end
    if (min_we && s1_last) begin
      job.chan      <= s1_chan;
      job.prompt    <= prompt_mode;
      job.sum       <= sum_new;
      job.fixed_ped <= fix_cur;
      job.minimum   <= min_new;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job_ready) |-> !(min_we && s1_last))
    else $error("job overwritten while pending");
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !in_ready)
    else $error("accepted item during write-back");
  a_single_wr: assert property (@(posedge clk) disable iff (rst)
    fix_we |-> !(sum_we || min_we))
    else $error("load and sample write together");
`endif

endmodule

// ===== design/wppf_back.sv =====
// ----------------------------------------------------------------------------
// wppf_back
// Computes the prompt pedestal by restoring division and forms the result.
// ----------------------------------------------------------------------------
module wppf_back #(
  parameter int ADC_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_valid,
  input  wppf_pkg::wppf_job_t          job,
  output logic                         job_ready,
  input  logic [wppf_pkg::IDX_W-1:0]   ped_count,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [wppf_pkg::CHAN_W-1:0]  res_chan,
  output logic [wppf_pkg::HGT_W-1:0]   res_height,
  output logic [wppf_pkg::PED_W-1:0]   res_ped
);
  import wppf_pkg::*;

  localparam logic [PED_W-1:0] PED_MAX = PED_W'(((1 << ADC_BITS) - 1) << 6);
  localparam int CNT_W = $clog2(QDIV_W + 1);

  wppf_state_t state, state_next;
  logic [QDIV_W-1:0] dividend, quot, quot_next;
  logic [IDX_W:0]    rem;
  logic [IDX_W+1:0]  trial;
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  divisor;
  logic [CHAN_W-1:0] chan;
  logic [ADCIN_W-1:0] minimum;
  logic [PED_W-1:0]  ped;
  logic [PED_W-1:0]  ped_sel;
  logic              load_job;

  assign job_ready = state == ST_IDLE;
  assign load_job  = job_valid && job_ready;
  assign res_valid = state == ST_RESULT;
  assign trial     = {rem, dividend[QDIV_W-1]} - {1'b0, 1'b0, divisor};
  assign quot_next = trial[IDX_W+1] ? {quot[QDIV_W-2:0], 1'b0} : {quot[QDIV_W-2:0], 1'b1};
  assign ped_sel   = (quot_next > QDIV_W'(PED_MAX)) ? PED_MAX : quot_next[PED_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          state_next = (job.prompt && ped_count != '0) ? ST_DIVIDE : ST_RESULT;
        end
      end
      ST_DIVIDE: begin
        if (cnt == CNT_W'(QDIV_W - 1)) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_job) begin
      chan     <= job.chan;
      minimum  <= job.minimum;
      dividend <= {job.sum, 6'b0};
      rem      <= '0;
      quot     <= '0;
      cnt      <= '0;
      divisor  <= ped_count;
      ped      <= job.prompt ? '0 : job.fixed_ped;
    end else if (state == ST_DIVIDE) begin
      dividend <= {dividend[QDIV_W-2:0], 1'b0};
      cnt      <= cnt + 1'b1;
      quot     <= quot_next;
      if (!trial[IDX_W+1]) begin
        rem  <= trial[IDX_W:0];
      end else begin
        rem  <= {rem[IDX_W-1:0], dividend[QDIV_W-1]};
      end
      if (cnt == CNT_W'(QDIV_W - 1)) begin
        ped <= ped_sel;
      end
    end
  end

  assign res_chan   = chan;
  assign res_ped    = ped;
  assign res_height = HGT_W'({1'b0, ped}) - HGT_W'({minimum, 6'b0});

`ifndef ASSERT_OFF
  a_ped_cap: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_ped <= PED_MAX)
    else $error("pedestal above maximum");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid && $stable(res_height))
    else $error("result dropped");
  a_cap_sel: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> ped_sel <= PED_MAX)
    else $error("clamp broken");
`endif

endmodule

// ===== design/waveform_pedestal_peak_finder.sv =====
// ----------------------------------------------------------------------------
// waveform_pedestal_peak_finder
// Pedestal-subtracted peak finder for an interleaved multi-channel digitizer.
// ----------------------------------------------------------------------------
// Each item passes through the front end as a state read, then a write-back
// to the per-channel state memories; the next item waits for the write-back.
// When a peak window closes, the back end forms the pedestal: a prompt pedestal
// is a restoring division of sum times 64 by ped_count, a fixed one skips it.
// A one-entry queue between the ends lets samples keep flowing while a
// division runs; while a job waits in that queue, the input stalls until the
// back end takes it. Results leave through a single output register.
module waveform_pedestal_peak_finder #(
  parameter int CHANNELS = 32,
  parameter int ADC_BITS = 12,
  parameter int SAMPLES_PER_EVENT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [wppf_pkg::CMD_W-1:0]    command,
  input  logic [wppf_pkg::CHAN_W-1:0]   channel,
  input  logic [wppf_pkg::IDX_W-1:0]    sample_index,
  input  logic [wppf_pkg::ADCIN_W-1:0]  adc_value,
  input  logic [wppf_pkg::PED_W-1:0]    pedestal_load,
  output logic                          empty,
  input  logic                          pop,
  output logic [wppf_pkg::CHAN_W-1:0]   out_channel,
  output logic signed [wppf_pkg::HGT_W-1:0] peak_height,
  output logic [wppf_pkg::PED_W-1:0]    pedestal_used,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wppf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wppf_pkg::CFG_DAT_W-1:0] cfg_data
);
  import wppf_pkg::*;

  logic prompt_mode;
  logic [31:0] channel_enable;
  logic [IDX_W-1:0] ped_first, ped_count, peak_first, peak_last;

  assign cfg_ready = 1'b1;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      prompt_mode    <= 1'b1;
      channel_enable <= 32'd15;
      ped_first      <= 10'd1;
      ped_count      <= 10'd50;
      peak_first     <= 10'd1;
      peak_last      <= 10'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROMPT_MODE:    prompt_mode    <= cfg_data[0];
        REG_CHANNEL_ENABLE: channel_enable <= cfg_data;
        REG_PED_FIRST:      ped_first      <= cfg_data[IDX_W-1:0];
        REG_PED_COUNT:      ped_count      <= cfg_data[IDX_W-1:0];
        REG_PEAK_FIRST:     peak_first     <= cfg_data[IDX_W-1:0];
        REG_PEAK_LAST:      peak_last      <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  logic in_ready;
  logic job_valid, job_ready;
  wppf_job_t job;
  logic res_valid, res_ready;
  logic [CHAN_W-1:0] res_chan;
  logic [HGT_W-1:0]  res_height;
  logic [PED_W-1:0]  res_ped;

  assign full = !in_ready;

  wppf_front #(.CHANNELS(CHANNELS), .ADC_BITS(ADC_BITS),
               .SAMPLES_PER_EVENT(SAMPLES_PER_EVENT)) u_front (
    .clk(clk), .rst(rst), .in_valid(push), .in_ready(in_ready),
    .command(command), .channel(channel), .sample_index(sample_index),
    .adc_value(adc_value), .pedestal_load(pedestal_load),
    .prompt_mode(prompt_mode), .channel_enable(channel_enable),
    .ped_first(ped_first), .ped_count(ped_count), .peak_first(peak_first),
    .peak_last(peak_last), .job_valid(job_valid), .job(job), .job_ready(job_ready));

  wppf_back #(.ADC_BITS(ADC_BITS)) u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job), .job_ready(job_ready),
    .ped_count(ped_count), .res_valid(res_valid), .res_ready(res_ready),
    .res_chan(res_chan), .res_height(res_height), .res_ped(res_ped));

  // Output register: one result held for the consumer.
  logic out_valid;
  assign res_ready = !out_valid || pop;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_channel   <= res_chan;
      peak_height   <= res_height;
      pedestal_used <= res_ped;
    end
  end

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(peak_height) && $stable(out_channel))
    else $error("waiting result changed");
  a_ped_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> pedestal_used <= 18'd262080)
    else $error("pedestal out of range");
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config port stalled");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pedestal-subtracted peak finder.
// ----------------------------------------------------------------------------
// A short directed table covers the height extremes, the load clamp, both
// commands, the empty and zero-length windows and the partial pedestal
// window. Random events follow: interleaved channels walk their sample
// windows under many register settings, with some noise items mixed in.
// Every accepted item runs through a local model of the block, and each
// popped result is compared with the oldest expected report.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wppf_pkg::*;

  localparam int  NCHAN        = 32;
  localparam int  ADC_MAX      = 4095;
  localparam int  PED_MAX      = ADC_MAX << 6;
  localparam int  SUM_MAX      = (1 << SUM_W) - 1;
  localparam int  ITEM_TARGET  = 1150;
  localparam int  QUIET_AFTER  = 1000;
  // Front end, a full division and the queues, with margin.
  localparam int  SETTLE       = 60;
  localparam int  CYCLE_LIMIT  = 2000000;

  typedef struct {
    logic [CHAN_W-1:0]       chan;
    logic signed [HGT_W-1:0] height;
    logic [PED_W-1:0]        ped;
  } peak_report_t;

  typedef enum {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CMD_W-1:0]     cmd;
    logic [CHAN_W-1:0]    chan;
    logic [IDX_W-1:0]     idx;
    logic [ADCIN_W-1:0]   adc;
    logic [PED_W-1:0]     load;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_val;
    bit                   typed;
    peak_report_t         report;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic push, full, empty, pop, cfg_valid, cfg_ready;
  logic [CMD_W-1:0]         command;
  logic [CHAN_W-1:0]        channel;
  logic [IDX_W-1:0]         sample_index;
  logic [ADCIN_W-1:0]       adc_value;
  logic [PED_W-1:0]         pedestal_load;
  logic [CHAN_W-1:0]        out_channel;
  logic signed [HGT_W-1:0]  peak_height;
  logic [PED_W-1:0]         pedestal_used;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DAT_W-1:0]     cfg_data;

  waveform_pedestal_peak_finder dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .channel(channel), .sample_index(sample_index), .adc_value(adc_value),
    .pedestal_load(pedestal_load), .empty(empty), .pop(pop),
    .out_channel(out_channel), .peak_height(peak_height),
    .pedestal_used(pedestal_used), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Local copy of the block's registers and per-channel state.
  logic                 m_prompt;
  logic [31:0]          m_enable;
  logic [IDX_W-1:0]     m_ped_first, m_ped_count, m_peak_first, m_peak_last;
  logic [PED_W-1:0]     m_fixed_ped [NCHAN];
  logic [SUM_W-1:0]     m_ped_sum   [NCHAN];
  logic [ADCIN_W-1:0]   m_win_min   [NCHAN];

  peak_report_t reports_due[$];
  stim_row_t    directed_rows[$];
  int  failures = 0;
  int  items_sent = 0;
  bit  quiet = 1'b0;
  int  cycles = 0;
  int  pop_hold = 0;

  // Apply one accepted request to the local state; returns 1 when the peak
  // window of that channel closes and a report is due.
  function automatic bit predict_peak(input logic [CMD_W-1:0] cmd,
                                      input logic [CHAN_W-1:0] ch,
                                      input logic [IDX_W-1:0] idx,
                                      input logic [ADCIN_W-1:0] adc,
                                      input logic [PED_W-1:0] load,
                                      output peak_report_t rep);
    longint ped;
    longint sum;
    rep = '{default: '0};
    if (cmd == CMD_LOAD) begin
      m_fixed_ped[ch] = (load > PED_MAX) ? PED_W'(PED_MAX) : load;
      return 1'b0;
    end
    if (!m_enable[ch]) return 1'b0;
    if (m_ped_count != 0) begin
      if (idx == m_ped_first) begin
        m_ped_sum[ch] = SUM_W'(adc);
      end else if (int'(idx) > int'(m_ped_first) &&
                   int'(idx) < int'(m_ped_first) + int'(m_ped_count)) begin
        sum = longint'(m_ped_sum[ch]) + longint'(adc);
        m_ped_sum[ch] = (sum > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(sum);
      end
    end
    if (m_peak_first > m_peak_last || idx < m_peak_first || idx > m_peak_last)
      return 1'b0;
    if (idx == m_peak_first || adc < m_win_min[ch]) m_win_min[ch] = adc;
    if (idx != m_peak_last) return 1'b0;
    if (!m_prompt) begin
      ped = longint'(m_fixed_ped[ch]);
    end else if (m_ped_count == 0) begin
      ped = 0;
    end else begin
      // The prompt pedestal is the truncated mean in Q6.
      ped = (longint'(m_ped_sum[ch]) * 64) / longint'(m_ped_count);
      if (ped > PED_MAX) ped = PED_MAX;
    end
    rep.chan   = ch;
    rep.height = HGT_W'(ped - (longint'(m_win_min[ch]) << 6));
    rep.ped    = PED_W'(ped);
    return 1'b1;
  endfunction

  // One request on the input side; inputs move on the falling edge and the
  // handshake is judged on the rising edge.
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [CHAN_W-1:0] ch,
                              input logic [IDX_W-1:0] idx,
                              input logic [ADCIN_W-1:0] adc,
                              input logic [PED_W-1:0] load,
                              input bit typed, input peak_report_t typed_rep);
    peak_report_t rep;
    int gap;
    if (!quiet && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
    end
    @(negedge clk);
    push <= 1'b1;
    command <= cmd;
    channel <= ch;
    sample_index <= idx;
    adc_value <= adc;
    pedestal_load <= load;
    do @(posedge clk); while (full);
    items_sent++;
    if (predict_peak(cmd, ch, idx, adc, load, rep))
      reports_due = {reports_due, (typed ? typed_rep : rep)};
    if (items_sent >= QUIET_AFTER) quiet = 1'b1;
  endtask

  task automatic drain_requests();
    @(negedge clk);
    push <= 1'b0;
    wait (reports_due.size() == 0);
  endtask

  // Registers change only when the block has gone quiet.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [31:0] val);
    drain_requests();
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (ri)
      REG_PROMPT_MODE:    m_prompt = val[0];
      REG_CHANNEL_ENABLE: m_enable = val;
      REG_PED_FIRST:      m_ped_first = val[IDX_W-1:0];
      REG_PED_COUNT:      m_ped_count = val[IDX_W-1:0];
      REG_PEAK_FIRST:     m_peak_first = val[IDX_W-1:0];
      REG_PEAK_LAST:      m_peak_last = val[IDX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void row_item(input logic [CMD_W-1:0] cmd, input int ch,
                                   input int idx, input int adc, input int load);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.cmd = cmd;
    r.chan = CHAN_W'(ch);
    r.idx = IDX_W'(idx);
    r.adc = ADCIN_W'(adc);
    r.load = PED_W'(load);
    r.reg_idx = '0;
    r.reg_val = '0;
    r.typed = 1'b0;
    r.report = '{default: '0};
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void row_expect(input int ch, input int adc, input int height,
                                     input int ped);
    row_item(CMD_SAMPLE, ch, 1000, adc, 0);
    directed_rows[$].typed = 1'b1;
    directed_rows[$].report = '{chan: CHAN_W'(ch), height: HGT_W'(height),
                                ped: PED_W'(ped)};
  endfunction

  function automatic void row_reg(input logic [CFG_IDX_W-1:0] ri, input logic [31:0] val);
    stim_row_t r;
    r.kind = ROW_REG;
    r.cmd = CMD_SAMPLE;
    r.chan = '0;
    r.idx = '0;
    r.adc = '0;
    r.load = '0;
    r.reg_idx = ri;
    r.reg_val = val;
    r.typed = 1'b0;
    r.report = '{default: '0};
    directed_rows = {directed_rows, r};
  endfunction

  function automatic logic [ADCIN_W-1:0] pick_adc();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ADCIN_W'(ADC_MAX);
      default: return ADCIN_W'($urandom);
    endcase
  endfunction

  // Random register setting for one phase; a few phases sit on the extremes.
  task automatic random_setting(input int phase);
    logic [IDX_W-1:0] pf, pc, kf, kl;
    logic [31:0] en;
    pf = IDX_W'($urandom_range(0, 4));
    pc = IDX_W'($urandom_range(1, 6));
    kf = IDX_W'($urandom_range(0, 8));
    kl = kf + IDX_W'($urandom_range(0, 8));
    en = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
    case (phase % 8)
      1: begin
        pf = IDX_W'(1023); pc = IDX_W'(1023); kf = IDX_W'(1023); kl = IDX_W'(1023);
      end
      3: pc = '0;
      5: begin kf = IDX_W'(9); kl = IDX_W'(3); end
      6: begin pf = '0; pc = IDX_W'(1023); kf = '0; kl = '0; end
      default: ;
    endcase
    write_reg(REG_PROMPT_MODE, $urandom_range(0, 1));
    write_reg(REG_CHANNEL_ENABLE, en);
    write_reg(REG_PED_FIRST, 32'(pf));
    write_reg(REG_PED_COUNT, 32'(pc));
    write_reg(REG_PEAK_FIRST, 32'(kf));
    write_reg(REG_PEAK_LAST, 32'(kl));
  endtask

  // One event: a few channels interleave their samples across both windows.
  task automatic random_event();
    int lo, hi, nch;
    logic [CHAN_W-1:0] chans[4];
    peak_report_t none;
    none = '{default: '0};
    nch = $urandom_range(1, 4);
    for (int k = 0; k < nch; k++) begin
      chans[k] = CHAN_W'($urandom);
      // Mostly enabled channels, so that windows actually close.
      for (int t = 0; t < 8 && !m_enable[chans[k]] && m_enable != 0; t++)
        chans[k] = CHAN_W'($urandom);
    end
    if (!m_prompt)
      for (int k = 0; k < nch; k++)
        send_request(CMD_LOAD, chans[k], IDX_W'($urandom), '0, PED_W'($urandom),
                     1'b0, none);
    hi = (m_peak_first > m_peak_last) ? int'(m_peak_first) : int'(m_peak_last);
    lo = (m_ped_first < m_peak_first) ? int'(m_ped_first) : int'(m_peak_first);
    if (hi - lo > 14) lo = hi - 14;
    for (int i = lo; i <= hi; i++)
      for (int k = 0; k < nch; k++) begin
        if ($urandom_range(0, 19) == 0)
          send_request(CMD_W'($urandom), CHAN_W'($urandom), IDX_W'($urandom),
                       ADCIN_W'($urandom), PED_W'($urandom), 1'b0, none);
        else
          send_request(CMD_SAMPLE, chans[k], IDX_W'(i), pick_adc(), PED_W'($urandom),
                       1'b0, none);
      end
  endtask

  // Result side: pop stalls come in random bursts until the quiet stretch.
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      pop_hold = $urandom_range(1, 10) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    peak_report_t want;
    cycles++;
    if (!rst && pop && !empty) begin
      if (reports_due.size() == 0) begin
        $error("unexpected result: channel %0d height %0d pedestal %0d",
               out_channel, peak_height, pedestal_used);
        failures++;
      end else begin
        want = reports_due.pop_front();
        if (out_channel !== want.chan) begin
          $error("out_channel: expected %0d, got %0d", want.chan, out_channel);
          failures++;
        end
        if (peak_height !== want.height) begin
          $error("peak_height: expected %0d, got %0d", want.height, peak_height);
          failures++;
        end
        if (pedestal_used !== want.ped) begin
          $error("pedestal_used: expected %0d, got %0d", want.ped, pedestal_used);
          failures++;
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    peak_report_t none;
    none = '{default: '0};
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    command = CMD_SAMPLE;
    channel = '0;
    sample_index = '0;
    adc_value = '0;
    pedestal_load = '0;
    m_prompt = 1'b1;
    m_enable = 32'd15;
    m_ped_first = IDX_W'(1);
    m_ped_count = IDX_W'(50);
    m_peak_first = IDX_W'(1);
    m_peak_last = IDX_W'(1000);
    for (int c = 0; c < NCHAN; c++) begin
      m_fixed_ped[c] = '0;
      m_ped_sum[c] = '0;
      m_win_min[c] = ADCIN_W'(ADC_MAX);
    end
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed table. At reset settings a sample at index 1 opens both
    // windows and one at index 1000 closes the peak window before the pedestal
    // window is full, so the pedestal comes from a partial sum.
    row_item(CMD_LOAD, 3, 0, 0, PED_MAX);
    row_item(CMD_LOAD, 31, 0, 0, (1 << PED_W) - 1);   // saturates
    row_item(CMD_SAMPLE, 0, 1, 0, 0);
    row_expect(0, 0, 0, 0);
    row_item(CMD_SAMPLE, 1, 1, ADC_MAX, 0);
    row_item(CMD_SAMPLE, 1, 1000, ADC_MAX, 0);
    row_item(CMD_SAMPLE, 5, 1000, 7, 0);               // disabled channel
    row_item(CMD_SAMPLE, 2, 1023, 12, 0);              // beyond the window
    // Fixed pedestals give both height extremes.
    row_reg(REG_PROMPT_MODE, 0);
    row_item(CMD_SAMPLE, 3, 1, 0, 0);
    row_expect(3, 0, PED_MAX, PED_MAX);
    row_item(CMD_SAMPLE, 0, 1, ADC_MAX, 0);
    row_expect(0, ADC_MAX, -PED_MAX, 0);
    // A peak window that ends before it starts never reports.
    row_reg(REG_PEAK_FIRST, 10);
    row_reg(REG_PEAK_LAST, 5);
    row_item(CMD_SAMPLE, 0, 5, 3, 0);
    row_item(CMD_SAMPLE, 0, 10, 3, 0);
    // A zero-length pedestal window gives a zero prompt pedestal.
    row_reg(REG_PROMPT_MODE, 1);
    row_reg(REG_PED_COUNT, 0);
    row_reg(REG_PEAK_FIRST, 1);
    row_reg(REG_PEAK_LAST, 1000);
    row_item(CMD_SAMPLE, 0, 1, 7, 0);
    row_expect(0, 7, -(7 << 6), 0);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_REG)
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
      else
        send_request(directed_rows[r].cmd, directed_rows[r].chan,
                     directed_rows[r].idx, directed_rows[r].adc,
                     directed_rows[r].load, directed_rows[r].typed,
                     directed_rows[r].report);
    end

    // Random phases until enough requests have gone in.
    for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
      random_setting(phase);
      repeat ($urandom_range(2, 5)) begin
        if (items_sent < ITEM_TARGET) random_event();
        // In one phase, hold the input side after each event until every report is out.
        if (phase == 2) drain_requests();
      end
    end

    drain_requests();
    repeat (SETTLE) @(posedge clk);
    if (failures == 0 && reports_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
